[rtl/largest_empty_square_finder_top_defines.svh]
// Assertion macros shared by the largest empty square finder RTL.
// Depends on nothing; the including module supplies i_clk and i_rst_n.
`ifndef LARGEST_EMPTY_SQUARE_FINDER_TOP_DEFINES_SVH
`define LARGEST_EMPTY_SQUARE_FINDER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LESF_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define LESF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/lesf_pkg.sv]
// Shared types and constants for the largest empty square finder.
// No dependencies.
package lesf_pkg;

    localparam int CHAR_W     = 8;
    localparam int SIZE_W     = 11;
    localparam int POS_W      = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam logic [CHAR_W-1:0] OBSTACLE_RST  = 8'd111;
    localparam logic [SIZE_W-1:0] ROW_COUNT_RST = 11'd1024;
    localparam logic [SIZE_W-1:0] COL_COUNT_RST = 11'd1024;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OBSTACLE  = 2'd0,
        CFG_ROW_COUNT = 2'd1,
        CFG_COL_COUNT = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [CHAR_W-1:0] obstacle_char;
        logic [SIZE_W-1:0] row_count;
        logic [SIZE_W-1:0] column_count;
    } t_cfg;

    typedef struct packed {
        logic [SIZE_W-1:0] cell_size;
        logic [SIZE_W-1:0] best_size;
        logic [POS_W-1:0]  best_row;
        logic [POS_W-1:0]  best_col;
        logic              map_done;
    } t_result;

endpackage

[rtl/lesf_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lesf_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 1024
) (
    input  logic                                    i_clk,
    input  logic                                    i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                        i_wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                        o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/lesf_cfg.sv]
// Configuration register file: obstacle character and map dimensions.
// Depends on lesf_pkg.
module lesf_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [lesf_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [lesf_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output lesf_pkg::t_cfg                   o_cfg
);
    import lesf_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.obstacle_char <= OBSTACLE_RST;
            r_cfg.row_count     <= ROW_COUNT_RST;
            r_cfg.column_count  <= COL_COUNT_RST;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_OBSTACLE:  r_cfg.obstacle_char <= i_cfg_data[CHAR_W-1:0];
                CFG_ROW_COUNT: r_cfg.row_count     <= i_cfg_data[SIZE_W-1:0];
                CFG_COL_COUNT: r_cfg.column_count  <= i_cfg_data[SIZE_W-1:0];
                default: begin
                    // unmapped index: drop the write
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[rtl/lesf_cell.sv]
// Per-cell square scoring: scan counters, left/diagonal scores, running best
// and line store addressing. Depends on lesf_pkg and the assertion macros.
`include "largest_empty_square_finder_top_defines.svh"

module lesf_cell #(
    parameter int MAX_ROWS = 1024,
    parameter int MAX_COLS = 1024
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  lesf_pkg::t_cfg                               i_cfg,
    input  logic                                         i_adv,
    input  logic [lesf_pkg::CHAR_W-1:0]                  i_cell_char,
    input  logic [lesf_pkg::SIZE_W-1:0]                  i_rd_data,
    output logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0] o_rd_addr,
    output logic                                         o_wr_en,
    output logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0] o_wr_addr,
    output logic [lesf_pkg::SIZE_W-1:0]                  o_wr_data,
    output lesf_pkg::t_result                            o_result
);
    import lesf_pkg::*;

    localparam int ROW_AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ROW_EW = ROW_AW + 1;
    localparam int COL_EW = COL_AW + 1;
    localparam int ROW_CW = (ROW_EW > SIZE_W) ? ROW_EW : SIZE_W;
    localparam int COL_CW = (COL_EW > SIZE_W) ? COL_EW : SIZE_W;

    logic [ROW_AW-1:0] r_row;
    logic [COL_AW-1:0] r_col;
    logic [SIZE_W-1:0] r_left;
    logic [SIZE_W-1:0] r_diag;
    logic [SIZE_W-1:0] r_best_size;
    logic [POS_W-1:0]  r_best_row;
    logic [POS_W-1:0]  r_best_col;
    logic              r_byp_vld;
    logic [SIZE_W-1:0] r_byp_data;

    logic [ROW_CW-1:0] row_cnt_ext;
    logic [COL_CW-1:0] col_cnt_ext;
    logic [ROW_EW-1:0] rows_eff;
    logic [COL_EW-1:0] cols_eff;
    logic [ROW_EW-1:0] row_inc;
    logic [COL_EW-1:0] col_inc;
    logic              last_row;
    logic              last_col;
    logic              done;
    logic [ROW_AW-1:0] n_row;
    logic [COL_AW-1:0] n_col;
    logic [SIZE_W-1:0] up;
    logic [SIZE_W-1:0] left;
    logic [SIZE_W-1:0] diag;
    logic [SIZE_W-1:0] min_ul;
    logic [SIZE_W-1:0] min_all;
    logic [SIZE_W-1:0] score;
    logic              better;
    logic [SIZE_W-1:0] n_best_size;
    logic [POS_W-1:0]  n_best_row;
    logic [POS_W-1:0]  n_best_col;

    // Zero counts act as one, oversize counts saturate at the store limits.
    assign row_cnt_ext = ROW_CW'(i_cfg.row_count);
    assign col_cnt_ext = COL_CW'(i_cfg.column_count);

    always_comb begin
        if (i_cfg.row_count == '0) begin
            rows_eff = ROW_EW'(1);
        end else if (row_cnt_ext > ROW_CW'(MAX_ROWS)) begin
            rows_eff = ROW_EW'(MAX_ROWS);
        end else begin
            rows_eff = ROW_EW'(row_cnt_ext);
        end
        if (i_cfg.column_count == '0) begin
            cols_eff = COL_EW'(1);
        end else if (col_cnt_ext > COL_CW'(MAX_COLS)) begin
            cols_eff = COL_EW'(MAX_COLS);
        end else begin
            cols_eff = COL_EW'(col_cnt_ext);
        end
    end

    assign row_inc  = {1'b0, r_row} + ROW_EW'(1);
    assign col_inc  = {1'b0, r_col} + COL_EW'(1);
    assign last_row = (row_inc >= rows_eff);
    assign last_col = (col_inc >= cols_eff);
    assign done     = last_row && last_col;

    always_comb begin
        if (done) begin
            n_row = '0;
            n_col = '0;
        end else if (last_col) begin
            n_row = row_inc[ROW_AW-1:0];
            n_col = '0;
        end else begin
            n_row = r_row;
            n_col = col_inc[COL_AW-1:0];
        end
    end

    // Take the score just written when the store read hit the same column.
    assign up   = (r_row == '0) ? '0 : (r_byp_vld ? r_byp_data : i_rd_data);
    assign left = (r_col == '0) ? '0 : r_left;
    assign diag = (r_row == '0 || r_col == '0) ? '0 : r_diag;

    assign min_ul  = (up < left) ? up : left;
    assign min_all = (min_ul < diag) ? min_ul : diag;
    assign score   = (i_cell_char == i_cfg.obstacle_char) ? '0 : min_all + SIZE_W'(1);

    // Strictly larger only, so the first square of a size keeps its corner.
    assign better      = (score > r_best_size);
    assign n_best_size = better ? score : r_best_size;
    assign n_best_row  = better ? POS_W'(r_row) : r_best_row;
    assign n_best_col  = better ? POS_W'(r_col) : r_best_col;

    // Present the next cell's column so its upper score is ready in time.
    assign o_rd_addr = i_adv ? n_col : r_col;
    assign o_wr_en   = i_adv;
    assign o_wr_addr = r_col;
    assign o_wr_data = score;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row       <= '0;
            r_col       <= '0;
            r_left      <= '0;
            r_diag      <= '0;
            r_best_size <= '0;
            r_best_row  <= '0;
            r_best_col  <= '0;
            r_byp_vld   <= 1'b0;
        end else begin
            r_byp_vld <= i_adv && (o_rd_addr == o_wr_addr);
            if (i_adv) begin
                r_row  <= n_row;
                r_col  <= n_col;
                r_left <= score;
                r_diag <= up;
                if (done) begin
                    r_best_size <= '0;
                    r_best_row  <= '0;
                    r_best_col  <= '0;
                end else begin
                    r_best_size <= n_best_size;
                    r_best_row  <= n_best_row;
                    r_best_col  <= n_best_col;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_byp_data <= score;
    end

    assign o_result.cell_size = score;
    assign o_result.best_size = n_best_size;
    assign o_result.best_row  = n_best_row;
    assign o_result.best_col  = n_best_col;
    assign o_result.map_done  = done;

    `LESF_ASSERT_NEXT(a_best_grows, i_adv && !done, r_best_size >= $past(r_best_size), "best size shrank within a map")
    `LESF_ASSERT_NEXT(a_map_restart, i_adv && done, r_row == '0 && r_col == '0 && r_best_size == '0, "scan state not cleared after map end")

endmodule

[rtl/largest_empty_square_finder_top.sv]
// Largest empty square finder, one map character per transfer in row-major
// order. Each accepted character yields one result: the side of the largest
// empty square ending at that cell, the map's best side so far with its
// bottom-right row and column, and a done flag on the map's last cell, after
// which the scan restarts for the next map. The block sustains one character
// per clock while the result output is not stalled. A result is offered from
// the result register that follows the input register. The row-above line
// store is indexed by column and read one cell ahead, so its registered read
// overlaps the input register. While a waiting result is stalled, a held
// character stalls the input. The line store needs no clearing after reset:
// the first row ignores the data that it reads from it. Write configuration
// only while no character is in flight, which may be part way through a map.
// Depends on lesf_pkg, lesf_cfg, lesf_cell and lesf_ram.
`include "largest_empty_square_finder_top_defines.svh"

module largest_empty_square_finder_top #(
    parameter int MAX_ROWS = 1024,
    parameter int MAX_COLS = 1024
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration
    input  logic                             i_cfg_wr_en,
    input  logic [lesf_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [lesf_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // character input
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [lesf_pkg::CHAR_W-1:0]      i_cell_char,
    // result output
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [lesf_pkg::SIZE_W-1:0]      o_cell_size,
    output logic [lesf_pkg::SIZE_W-1:0]      o_best_size,
    output logic [lesf_pkg::POS_W-1:0]       o_best_row,
    output logic [lesf_pkg::POS_W-1:0]       o_best_col,
    output logic                             o_map_done
);
    import lesf_pkg::*;

    localparam int COL_AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

    t_cfg              cfg;
    t_result           result;
    logic              r_in_vld;
    logic [CHAR_W-1:0] r_in_char;
    logic              r_out_vld;
    t_result           r_out;
    logic              adv;
    logic              in_xfer;
    logic              out_xfer;
    logic [COL_AW-1:0] rd_addr;
    logic [COL_AW-1:0] wr_addr;
    logic              wr_en;
    logic [SIZE_W-1:0] wr_data;
    logic [SIZE_W-1:0] rd_data;

    lesf_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    lesf_ram #(
        .WIDTH (SIZE_W),
        .DEPTH (MAX_COLS)
    ) u_line (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    lesf_cell #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_cell (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_adv       (adv),
        .i_cell_char (r_in_char),
        .i_rd_data   (rd_data),
        .o_rd_addr   (rd_addr),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_result    (result)
    );

    // Advance the held character whenever the result register can take it.
    assign adv        = r_in_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall = r_in_vld && !adv;
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign out_xfer   = r_out_vld && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_xfer) begin
            r_in_vld <= 1'b1;
        end else if (adv) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_char <= i_cell_char;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= 1'b1;
        end else if (out_xfer) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_cell_size = r_out.cell_size;
    assign o_best_size = r_out.best_size;
    assign o_best_row  = r_out.best_row;
    assign o_best_col  = r_out.best_col;
    assign o_map_done  = r_out.map_done;

    `LESF_ASSERT_IMP(a_cell_within_best, r_out_vld, r_out.cell_size <= r_out.best_size, "cell size above running best")
    `LESF_ASSERT_NEXT(a_adv_loads_out, adv, r_out_vld, "advanced item did not reach the result register")

endmodule
